### src/tilt_compensated_compass_top_macros.svh
// Assertion macros shared by the compass block. Each expands to one
// labeled concurrent assertion clocked by aclk and held off during reset.
`ifndef TILT_COMPENSATED_COMPASS_TOP_MACROS_SVH
`define TILT_COMPENSATED_COMPASS_TOP_MACROS_SVH

// Two expressions must agree at every clock edge.
`define TCC_ASSERT_EQ(lbl, a, b) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) == (b)) \
        else $error("compass: signals that should agree differ");

// When the antecedent holds, the consequent holds in the next cycle.
`define TCC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("compass: next-cycle property failed");

`endif

### src/tcc_pkg.sv
`default_nettype none

package tcc_pkg;

    // Number of CORDIC micro-rotations; the arctangent table covers up to 24.
    localparam int CORDIC_STAGES = 16;
    localparam int TAB_LEN       = 24;

    localparam int AW  = 16;  // output binary angle
    localparam int ZW  = 32;  // angle accumulator, 2^32 counts per turn
    localparam int VW  = 48;  // vectoring datapath, holds the heading terms
    localparam int SCW = 33;  // sine and cosine, Q30
    localparam int TW  = 34;  // residual angle in the rotation unit

    localparam int SQ_BITS = 28;            // bits of the Q16 magnitude
    localparam int SQ_LAT  = SQ_BITS + 1;   // squares stage plus one stage per bit
    localparam int VEC_LAT = CORDIC_STAGES + 2;
    localparam int ROT_LAT = CORDIC_STAGES + 2;
    localparam int MIX_LAT = 5;

    localparam logic [ZW-1:0] ANGLE_PI = 32'h8000_0000;
    localparam logic signed [SCW-1:0] INV_GAIN = 33'sd652032874;

    localparam logic [ZW-1:0] ATAN_TAB [TAB_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41721,     32'd20860,
        32'd10430,     32'd5215,      32'd2607,      32'd1303,
        32'd651,       32'd325,       32'd162,       32'd81
    };

    typedef enum logic [2:0] {
        REG_CENTER_X = 3'd0,
        REG_CENTER_Y = 3'd1,
        REG_CENTER_Z = 3'd2,
        REG_GAIN_X   = 3'd3,
        REG_GAIN_Y   = 3'd4,
        REG_GAIN_Z   = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic signed [12:0] center_x;
        logic signed [12:0] center_y;
        logic signed [12:0] center_z;
        logic [11:0]        gain_x;
        logic [11:0]        gain_y;
        logic [11:0]        gain_z;
    } tcc_cfg_t;

endpackage

`default_nettype wire

### src/tcc_sqrt.sv
`default_nettype none

module tcc_sqrt (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         en,
    input  wire logic                         in_valid,
    input  wire logic signed [11:0]           accel_y,
    input  wire logic signed [11:0]           accel_z,
    output logic                              out_valid,
    output logic [tcc_pkg::SQ_BITS-1:0]       root
);
    import tcc_pkg::*;

    localparam int RW = 2 * SQ_BITS + 2;

    logic [SQ_LAT-1:0]  valid_reg;
    logic [23:0]        sum_reg;
    logic signed [23:0] sq_y;
    logic signed [23:0] sq_z;
    logic [RW-1:0]      rem_reg  [SQ_BITS];
    logic [SQ_BITS-1:0] root_reg [SQ_BITS];
    logic [RW-1:0]      rem_in   [SQ_BITS];
    logic [SQ_BITS-1:0] root_in  [SQ_BITS];

    assign sq_y = 24'(accel_y) * 24'(accel_y);
    assign sq_z = 24'(accel_z) * 24'(accel_z);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[SQ_LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg <= 24'(unsigned'(sq_y) + unsigned'(sq_z));
        end
    end

    // One result bit per stage, most significant first (restoring method).
    for (genvar j = 0; j < SQ_BITS; j++) begin : g_bit
        localparam int K = SQ_BITS - 1 - j;
        logic [RW-1:0] cand;
        logic          fits;

        if (j == 0) begin : g_first
            assign rem_in[j]  = RW'({sum_reg, 32'd0});
            assign root_in[j] = '0;
        end else begin : g_rest
            assign rem_in[j]  = rem_reg[j-1];
            assign root_in[j] = root_reg[j-1];
        end

        assign cand = (RW'(root_in[j]) << (K + 1)) + (RW'(1) << (2 * K));
        assign fits = rem_in[j] >= cand;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j]  <= fits ? rem_in[j] - cand : rem_in[j];
                root_reg[j] <= root_in[j] | (SQ_BITS'(fits) << K);
            end
        end
    end

    assign out_valid = valid_reg[SQ_LAT-1];
    assign root      = root_reg[SQ_BITS-1];

endmodule

`default_nettype wire

### src/tcc_vec.sv
`default_nettype none

module tcc_vec (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         en,
    input  wire logic                         in_valid,
    input  wire logic signed [tcc_pkg::VW-1:0] x_in,
    input  wire logic signed [tcc_pkg::VW-1:0] y_in,
    output logic                              out_valid,
    output logic [tcc_pkg::AW-1:0]            angle
);
    import tcc_pkg::*;

    logic [VEC_LAT-1:0]    valid_reg;
    logic signed [VW-1:0]  x_reg    [CORDIC_STAGES+1];
    logic signed [VW-1:0]  y_reg    [CORDIC_STAGES+1];
    logic [ZW-1:0]         z_reg    [CORDIC_STAGES+1];
    logic                  zero_reg [CORDIC_STAGES+1];
    logic [AW-1:0]         angle_reg;
    logic [ZW-1:0]         z_round;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[VEC_LAT-2:0], in_valid};
        end
    end

    // Fold the left half plane onto the right one and start the angle at pi.
    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= x_in[VW-1] ? -x_in : x_in;
            y_reg[0]    <= x_in[VW-1] ? -y_in : y_in;
            z_reg[0]    <= x_in[VW-1] ? ANGLE_PI : '0;
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        always_ff @(posedge aclk) begin
            if (en) begin
                if (!y_reg[i][VW-1]) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATAN_TAB[i];
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATAN_TAB[i];
                end
                zero_reg[i+1] <= zero_reg[i];
            end
        end
    end

    assign z_round = z_reg[CORDIC_STAGES] + 32'h0000_8000;

    // A zero vector has no direction and reports angle zero.
    always_ff @(posedge aclk) begin
        if (en) begin
            angle_reg <= zero_reg[CORDIC_STAGES] ? '0 : z_round[ZW-1:ZW-AW];
        end
    end

    assign out_valid = valid_reg[VEC_LAT-1];
    assign angle     = angle_reg;

endmodule

`default_nettype wire

### src/tcc_rot.sv
`default_nettype none

module tcc_rot (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [tcc_pkg::AW-1:0]        angle,
    output logic                               out_valid,
    output logic signed [tcc_pkg::SCW-1:0]     cos_out,
    output logic signed [tcc_pkg::SCW-1:0]     sin_out
);
    import tcc_pkg::*;

    localparam logic signed [TW-1:0] T_HALF_PI = 34'sd1073741824;
    localparam logic signed [TW-1:0] T_PI      = 34'sd2147483648;

    logic [ROT_LAT-1:0]    valid_reg;
    logic signed [SCW-1:0] x_reg   [CORDIC_STAGES+1];
    logic signed [SCW-1:0] y_reg   [CORDIC_STAGES+1];
    logic signed [TW-1:0]  t_reg   [CORDIC_STAGES+1];
    logic                  neg_reg [CORDIC_STAGES+1];
    logic signed [SCW-1:0] cos_reg;
    logic signed [SCW-1:0] sin_reg;
    logic signed [TW-1:0]  t_in;

    assign t_in = {{(TW-AW-16){angle[AW-1]}}, angle, 16'd0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[ROT_LAT-2:0], in_valid};
        end
    end

    // Angles past a quarter turn are brought back by pi; the results flip sign.
    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0] <= INV_GAIN;
            y_reg[0] <= '0;
            if (t_in > T_HALF_PI) begin
                t_reg[0]   <= t_in - T_PI;
                neg_reg[0] <= 1'b1;
            end else if (t_in < -T_HALF_PI) begin
                t_reg[0]   <= t_in + T_PI;
                neg_reg[0] <= 1'b1;
            end else begin
                t_reg[0]   <= t_in;
                neg_reg[0] <= 1'b0;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        logic signed [TW-1:0] step;
        assign step = $signed({2'b00, ATAN_TAB[i]});

        always_ff @(posedge aclk) begin
            if (en) begin
                if (!t_reg[i][TW-1]) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    t_reg[i+1] <= t_reg[i] - step;
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    t_reg[i+1] <= t_reg[i] + step;
                end
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg <= neg_reg[CORDIC_STAGES] ? -x_reg[CORDIC_STAGES] : x_reg[CORDIC_STAGES];
            sin_reg <= neg_reg[CORDIC_STAGES] ? -y_reg[CORDIC_STAGES] : y_reg[CORDIC_STAGES];
        end
    end

    assign out_valid = valid_reg[ROT_LAT-1];
    assign cos_out   = cos_reg;
    assign sin_out   = sin_reg;

endmodule

`default_nettype wire

### src/tcc_mix.sv
`default_nettype none

module tcc_mix (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire tcc_pkg::tcc_cfg_t             cfg,
    input  wire logic signed [12:0]            mag_x,
    input  wire logic signed [12:0]            mag_y,
    input  wire logic signed [12:0]            mag_z,
    input  wire logic signed [tcc_pkg::SCW-1:0] cos_r,
    input  wire logic signed [tcc_pkg::SCW-1:0] sin_r,
    input  wire logic signed [tcc_pkg::SCW-1:0] cos_p,
    input  wire logic signed [tcc_pkg::SCW-1:0] sin_p,
    output logic                               out_valid,
    output logic signed [tcc_pkg::VW-1:0]      num,
    output logic signed [tcc_pkg::VW-1:0]      den
);
    import tcc_pkg::*;

    localparam int XW = 28;   // centered and scaled field
    localparam int PW = 61;   // field times Q30 sine or cosine
    localparam int IW = 30;   // inner term after the Q30 shift
    localparam int QW = 64;

    logic [MIX_LAT-1:0]    valid_reg;
    logic signed [14:0]    dx, dy, dz;

    logic signed [XW-1:0]  x0_reg, y0_reg, z0_reg;
    logic signed [SCW-1:0] cr0_reg, sr0_reg, cp0_reg, sp0_reg;

    logic signed [PW-1:0]  p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [SCW-1:0] sp1_reg;

    logic signed [PW:0]    diff1, sum1;
    logic signed [VW-1:0]  num2_reg;
    logic signed [IW-1:0]  inner2_reg;
    logic signed [PW-1:0]  p5_2_reg;
    logic signed [SCW-1:0] sp2_reg;

    logic signed [QW-1:0]  q3_reg;
    logic signed [VW-1:0]  num3_reg;
    logic signed [PW-1:0]  p5_3_reg;

    logic signed [QW-1:0]  den_sum;
    logic signed [VW-1:0]  num4_reg, den4_reg;

    // Centering: twice the sample minus the calibration min+max sum.
    assign dx = {mag_x[12], mag_x, 1'b0} - {{2{cfg.center_x[12]}}, cfg.center_x};
    assign dy = {mag_y[12], mag_y, 1'b0} - {{2{cfg.center_y[12]}}, cfg.center_y};
    assign dz = {mag_z[12], mag_z, 1'b0} - {{2{cfg.center_z[12]}}, cfg.center_z};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[MIX_LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x0_reg  <= XW'(dx) * XW'($signed({1'b0, cfg.gain_x}));
            y0_reg  <= XW'(dy) * XW'($signed({1'b0, cfg.gain_y}));
            z0_reg  <= XW'(dz) * XW'($signed({1'b0, cfg.gain_z}));
            cr0_reg <= cos_r;
            sr0_reg <= sin_r;
            cp0_reg <= cos_p;
            sp0_reg <= sin_p;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg  <= PW'(z0_reg) * PW'(sr0_reg);
            p2_reg  <= PW'(y0_reg) * PW'(cr0_reg);
            p3_reg  <= PW'(y0_reg) * PW'(sr0_reg);
            p4_reg  <= PW'(z0_reg) * PW'(cr0_reg);
            p5_reg  <= PW'(x0_reg) * PW'(cp0_reg);
            sp1_reg <= sp0_reg;
        end
    end

    assign diff1 = (PW+1)'(p1_reg) - (PW+1)'(p2_reg);
    assign sum1  = (PW+1)'(p3_reg) + (PW+1)'(p4_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            num2_reg   <= VW'(diff1 >>> 14);
            inner2_reg <= IW'(sum1 >>> 30);
            p5_2_reg   <= p5_reg;
            sp2_reg    <= sp1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q3_reg   <= QW'(inner2_reg) * QW'(sp2_reg);
            num3_reg <= num2_reg;
            p5_3_reg <= p5_2_reg;
        end
    end

    assign den_sum = QW'(p5_3_reg) + q3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            den4_reg <= VW'(den_sum >>> 14);
            num4_reg <= num3_reg;
        end
    end

    assign out_valid = valid_reg[MIX_LAT-1];
    assign num       = num4_reg;
    assign den       = den4_reg;

endmodule

`default_nettype wire

### src/tilt_compensated_compass_top.sv
// Tilt-compensated compass. Each transfer on the s_ channel carries one
// accelerometer sample and one magnetometer sample; each produces exactly one
// transfer on the m_ channel with pitch, roll and heading as 16-bit binary
// angles (32768 counts make pi). Calibration registers are written through
// the cfg_ port, one register per cycle with cfg_we high, and must be written
// only while no sample is in flight; the block itself does not enforce this.
// The path runs through the bit-per-stage square root, three CORDIC units
// (pitch and roll arctangent side by side, both sine/cosine units side by
// side, then the heading arctangent), the heading products and one output
// register. Every stage is a register, so while the output is not stalled
// one transfer is taken each cycle and the throughput is one sample per clock.
// Reset (aresetn low at a clock edge) clears all valid bits and loads the
// calibration registers with their default values; data in flight is lost.
// When the receiver holds m_tready low while m_tvalid is high the whole
// pipeline freezes and s_tready goes low; nothing is dropped or repeated.
`default_nettype none

module tilt_compensated_compass_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // accel_x[11:0], accel_y[23:12], accel_z[35:24], mag_x[48:36],
    // mag_y[61:49], mag_z[74:62], zero fill [79:75]
    input  wire logic [79:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // pitch_angle[15:0], roll_angle[31:16], heading_angle[47:32]
    output logic [47:0]      m_tdata,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [12:0] cfg_data
);
    import tcc_pkg::*;

    localparam int MAG_DLY = SQ_LAT + VEC_LAT + ROT_LAT;
    localparam int ANG_DLY = ROT_LAT + MIX_LAT + VEC_LAT;

    // Calibration registers.
    tcc_cfg_t cfg_reg, cfg_next;

    // The whole pipeline advances together unless the output is stalled.
    logic pipe_en;

    logic signed [11:0] accel_x, accel_y, accel_z;
    logic signed [12:0] mag_x, mag_y, mag_z;

    logic                 sq_valid;
    logic [SQ_BITS-1:0]   sq_root;
    logic [35:0]          acc_dly_reg [SQ_LAT];
    logic [38:0]          mag_dly_reg [MAG_DLY];
    logic [31:0]          ang_dly_reg [ANG_DLY];

    logic signed [11:0]   ax_d, ay_d, az_d;
    logic signed [VW-1:0] pitch_x, pitch_y, roll_x, roll_y;
    logic                 pitch_valid, roll_valid;
    logic [AW-1:0]        pitch_ang, roll_ang, neg_pitch;

    logic                  rot_r_valid, rot_p_valid;
    logic signed [SCW-1:0] cos_r, sin_r, cos_p, sin_p;

    logic                 mix_valid;
    logic signed [VW-1:0] head_num, head_den;

    logic                 head_valid;
    logic [AW-1:0]        head_ang;

    logic                 m_valid_reg;
    logic [47:0]          m_data_reg;

    assign pipe_en  = !m_valid_reg || m_tready;
    assign s_tready = pipe_en;

    assign accel_x = s_tdata[11:0];
    assign accel_y = s_tdata[23:12];
    assign accel_z = s_tdata[35:24];
    assign mag_x   = s_tdata[48:36];
    assign mag_y   = s_tdata[61:49];
    assign mag_z   = s_tdata[74:62];

    // Register decode; indexes beyond the list are ignored.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_CENTER_X: cfg_next.center_x = cfg_data;
                REG_CENTER_Y: cfg_next.center_y = cfg_data;
                REG_CENTER_Z: cfg_next.center_z = cfg_data;
                REG_GAIN_X:   cfg_next.gain_x   = cfg_data[11:0];
                REG_GAIN_Y:   cfg_next.gain_y   = cfg_data[11:0];
                REG_GAIN_Z:   cfg_next.gain_z   = cfg_data[11:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.center_x <= 13'sd23;
            cfg_reg.center_y <= -13'sd147;
            cfg_reg.center_z <= 13'sd1;
            cfg_reg.gain_x   <= 12'd783;
            cfg_reg.gain_y   <= 12'd787;
            cfg_reg.gain_z   <= 12'd821;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Magnitude of the y/z accelerometer components in Q16.
    tcc_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (s_tvalid),
        .accel_y   (accel_y),
        .accel_z   (accel_z),
        .out_valid (sq_valid),
        .root      (sq_root)
    );

    // Accelerometer samples wait alongside the square root.
    for (genvar k = 0; k < SQ_LAT; k++) begin : g_acc_dly
        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                if (k == 0) begin
                    acc_dly_reg[k] <= {accel_z, accel_y, accel_x};
                end else begin
                    acc_dly_reg[k] <= acc_dly_reg[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    assign ax_d = acc_dly_reg[SQ_LAT-1][11:0];
    assign ay_d = acc_dly_reg[SQ_LAT-1][23:12];
    assign az_d = acc_dly_reg[SQ_LAT-1][35:24];

    // Accelerometer terms enter the arctangent scaled by 2^16.
    assign pitch_x = VW'(sq_root);
    assign pitch_y = -(VW'(ax_d) <<< 16);
    assign roll_x  = VW'(az_d) <<< 16;
    assign roll_y  = VW'(ay_d) <<< 16;

    tcc_vec u_vec_pitch (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (sq_valid),
        .x_in      (pitch_x),
        .y_in      (pitch_y),
        .out_valid (pitch_valid),
        .angle     (pitch_ang)
    );

    tcc_vec u_vec_roll (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (sq_valid),
        .x_in      (roll_x),
        .y_in      (roll_y),
        .out_valid (roll_valid),
        .angle     (roll_ang)
    );

    // The heading rotation uses the negated pitch.
    assign neg_pitch = AW'(0) - pitch_ang;

    tcc_rot u_rot_roll (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (roll_valid),
        .angle     (roll_ang),
        .out_valid (rot_r_valid),
        .cos_out   (cos_r),
        .sin_out   (sin_r)
    );

    tcc_rot u_rot_pitch (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (pitch_valid),
        .angle     (neg_pitch),
        .out_valid (rot_p_valid),
        .cos_out   (cos_p),
        .sin_out   (sin_p)
    );

    // Magnetometer samples wait until the sines and cosines are ready.
    for (genvar k = 0; k < MAG_DLY; k++) begin : g_mag_dly
        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                if (k == 0) begin
                    mag_dly_reg[k] <= {mag_z, mag_y, mag_x};
                end else begin
                    mag_dly_reg[k] <= mag_dly_reg[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    tcc_mix u_mix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (rot_r_valid),
        .cfg       (cfg_reg),
        .mag_x     (mag_dly_reg[MAG_DLY-1][12:0]),
        .mag_y     (mag_dly_reg[MAG_DLY-1][25:13]),
        .mag_z     (mag_dly_reg[MAG_DLY-1][38:26]),
        .cos_r     (cos_r),
        .sin_r     (sin_r),
        .cos_p     (cos_p),
        .sin_p     (sin_p),
        .out_valid (mix_valid),
        .num       (head_num),
        .den       (head_den)
    );

    tcc_vec u_vec_head (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (mix_valid),
        .x_in      (head_den),
        .y_in      (head_num),
        .out_valid (head_valid),
        .angle     (head_ang)
    );

    // Pitch and roll wait for the heading.
    for (genvar k = 0; k < ANG_DLY; k++) begin : g_ang_dly
        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                if (k == 0) begin
                    ang_dly_reg[k] <= {roll_ang, pitch_ang};
                end else begin
                    ang_dly_reg[k] <= ang_dly_reg[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    // Output register: holds a finished result until the receiver takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            m_valid_reg <= head_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            m_data_reg <= {head_ang, ang_dly_reg[ANG_DLY-1]};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`include "tilt_compensated_compass_top_macros.svh"

    // Pitch and roll arctangents run in lockstep on the same samples.
    `TCC_ASSERT_EQ(a_vec_lockstep, pitch_valid, roll_valid)
    // Both sine/cosine units run in lockstep as well.
    `TCC_ASSERT_EQ(a_rot_lockstep, rot_r_valid, rot_p_valid)
    // A stalled output freezes the pipeline behind it.
    `TCC_ASSERT_NEXT(a_stall_freeze, m_tvalid && !m_tready, $stable(head_valid))

endmodule

`default_nettype wire

### test/tilt_compensated_compass_top_tb.sv
`default_nettype none

// Self-checking bench for the tilt-compensated compass. An initial block
// queues sensor samples phase by phase and rewrites the calibration between
// phases. A clocked driver offers the queued samples on the s_ channel and a
// clocked monitor takes results from the m_ channel. Each result is checked
// against angles that the bench computes on its own from the same samples.
module tilt_compensated_compass_top_tb;
    import tcc_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 3 * CORDIC_STAGES + 60;
    localparam int HOLD_CYCLES  = 400;

    // Register indexes that the block does not implement; writes there are ignored.
    localparam logic [2:0] REG_SPARE_6 = 3'd6;
    localparam logic [2:0] REG_SPARE_7 = 3'd7;

    typedef struct {
        logic signed [11:0] ax, ay, az;
        logic signed [12:0] mx, my, mz;
    } sensor_sample_t;

    typedef struct {
        logic [15:0] pitch, roll, heading;
    } attitude_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // accel_x, accel_y, accel_z (12 bits each), mag_x, mag_y, mag_z (13 bits each)
    logic [79:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // pitch_angle, roll_angle, heading_angle
    logic [47:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [12:0] cfg_data = '0;

    sensor_sample_t pending_samples[$];
    attitude_t      expected_angles[$];
    tcc_cfg_t       cal_model;
    int             failures = 0;
    int             samples_taken = 0;
    int             cycle_count = 0;
    int             send_gap = 0;
    int             recv_gap = 0;
    int             hold_left = 0;
    bit             hold_done = 1'b0;
    // When set, neither side inserts idle cycles.
    bit             steady = 1'b0;

    tilt_compensated_compass_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // ---------------------------------------------------------------------
    // Angle arithmetic. Angles are binary: 2^32 counts per turn in the
    // accumulators, 2^16 on the ports. Shifts of signed values round down.
    // ---------------------------------------------------------------------
    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Vectoring CORDIC; a vector in the left half plane is turned by pi first.
    function automatic logic [31:0] vector_angle(longint y, longint x);
        logic [31:0] z;
        longint nx;
        z = '0;
        if (x == 0 && y == 0) return '0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = ANGLE_PI;
        end
        for (int i = 0; i < CORDIC_STAGES && i < TAB_LEN; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + ATAN_TAB[i];
            end else begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - ATAN_TAB[i];
            end
            x = nx;
        end
        return z;
    endfunction

    function automatic logic [15:0] to_port_angle(logic [31:0] z);
        logic [31:0] r;
        r = z + 32'h0000_8000;
        return r[31:16];
    endfunction

    // Rotation CORDIC giving Q30 cosine and sine; angles past a quarter turn
    // are folded back by pi and the results negated.
    function automatic void cos_sin_q30(input logic [15:0] a, output longint c,
                                        output longint s);
        longint t, x, y, nx;
        bit     flip;
        t = longint'($signed(a)) * 65536;
        x = INV_GAIN;
        y = 0;
        flip = 1'b0;
        if (t > 64'sd1073741824) begin
            t = t - 64'sd2147483648;
            flip = 1'b1;
        end else if (t < -64'sd1073741824) begin
            t = t + 64'sd2147483648;
            flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_STAGES && i < TAB_LEN; i++) begin
            if (t >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                t  = t - longint'(ATAN_TAB[i]);
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                t  = t + longint'(ATAN_TAB[i]);
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic attitude_t predict_attitude(sensor_sample_t smp);
        attitude_t res;
        longint ax, ay, az, bx, by, bz, cr, sr, cp, sp, num, inner, den;
        longint unsigned mag;
        ax = smp.ax;
        ay = smp.ay;
        az = smp.az;
        mag = floor_sqrt(longint'(ay * ay + az * az) << 32);
        res.pitch = to_port_angle(vector_angle(-ax * 65536, longint'(mag)));
        res.roll  = to_port_angle(vector_angle(ay * 65536, az * 65536));
        // Hard-iron centering, then per-axis gain.
        bx = (2 * longint'(smp.mx) - longint'(cal_model.center_x)) * longint'(cal_model.gain_x);
        by = (2 * longint'(smp.my) - longint'(cal_model.center_y)) * longint'(cal_model.gain_y);
        bz = (2 * longint'(smp.mz) - longint'(cal_model.center_z)) * longint'(cal_model.gain_z);
        cos_sin_q30(res.roll, cr, sr);
        cos_sin_q30(16'h0000 - res.pitch, cp, sp);
        num   = (bz * sr - by * cr) >>> 14;
        inner = (by * sr + bz * cr) >>> 30;
        den   = (bx * cp + inner * sp) >>> 14;
        res.heading = to_port_angle(vector_angle(num, den));
        return res;
    endfunction

    // ---------------------------------------------------------------------
    // Calibration writes, mirrored into the bench's own register copy.
    // ---------------------------------------------------------------------
    task automatic write_cal(input logic [2:0] idx, input logic [12:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_CENTER_X: cal_model.center_x = val;
            REG_CENTER_Y: cal_model.center_y = val;
            REG_CENTER_Z: cal_model.center_z = val;
            REG_GAIN_X:   cal_model.gain_x   = val[11:0];
            REG_GAIN_Y:   cal_model.gain_y   = val[11:0];
            REG_GAIN_Z:   cal_model.gain_z   = val[11:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_calibration(input logic [12:0] cx, cy, cz, input logic [11:0] gx, gy, gz);
        write_cal(REG_CENTER_X, cx);
        write_cal(REG_CENTER_Y, cy);
        write_cal(REG_CENTER_Z, cz);
        write_cal(REG_GAIN_X, {1'b0, gx});
        write_cal(REG_GAIN_Y, {1'b0, gy});
        write_cal(REG_GAIN_Z, {1'b0, gz});
    endtask

    task automatic queue_sample(input int ax, ay, az, mx, my, mz);
        sensor_sample_t smp;
        smp.ax = ax[11:0];
        smp.ay = ay[11:0];
        smp.az = az[11:0];
        smp.mx = mx[12:0];
        smp.my = my[12:0];
        smp.mz = mz[12:0];
        pending_samples.push_back(smp);
    endtask

    // Mostly uniform samples over every bit, with some tilted-at-rest accel
    // vectors, zero accel vectors and full-scale corners mixed in.
    task automatic queue_random(input int count);
        int kind;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
                queue_sample(0, 0, 0, $urandom, $urandom, $urandom);
            else if (kind == 1)
                queue_sample($urandom_range(0, 1) ? 2047 : -2048,
                             $urandom_range(0, 1) ? 2047 : -2048,
                             $urandom_range(0, 1) ? 2047 : -2048,
                             $urandom_range(0, 1) ? 4095 : -4096,
                             $urandom_range(0, 1) ? 4095 : -4096,
                             $urandom_range(0, 1) ? 4095 : -4096);
            else if (kind < 5)
                queue_sample($signed($urandom_range(0, 400)) - 200,
                             $signed($urandom_range(0, 400)) - 200,
                             $signed($urandom_range(0, 2047)),
                             $signed($urandom_range(0, 1200)) - 600,
                             $signed($urandom_range(0, 1200)) - 600,
                             $signed($urandom_range(0, 1200)) - 600);
            else
                queue_sample($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    // Blocks until every queued sample has gone in and every result has come
    // out, then lets the pipeline run dry before the calibration changes.
    task automatic drain;
        while (pending_samples.size() != 0 || expected_angles.size() != 0 || s_tvalid)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // ---------------------------------------------------------------------
    // Stimulus sequence.
    // ---------------------------------------------------------------------
    initial begin
        cal_model.center_x = 13'sd23;
        cal_model.center_y = -13'sd147;
        cal_model.center_z = 13'sd1;
        cal_model.gain_x   = 12'd783;
        cal_model.gain_y   = 12'd787;
        cal_model.gain_z   = 12'd821;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed samples against the reset calibration, with no idling.
        steady = 1'b1;
        queue_sample(0, 0, 0, 0, 0, 0);              // zero vectors everywhere
        queue_sample(0, 0, 1000, 300, -200, 100);    // level
        queue_sample(0, 0, -1000, 300, -200, 100);   // upside down: roll of pi
        queue_sample(0, 0, -2048, -4096, 4095, -4096);
        queue_sample(-2048, 0, 0, 100, 100, 100);    // pitch straight up
        queue_sample(2047, 0, 0, 100, 100, 100);     // pitch straight down
        queue_sample(0, 2047, 0, 4095, 4095, 4095);
        queue_sample(0, -2048, 0, -4096, -4096, -4096);
        queue_sample(-2048, -2048, -2048, 4095, -4096, 4095);
        queue_sample(2047, 2047, 2047, -4096, 4095, -4096);
        queue_sample(0, 0, 1000, 12, -74, 0);        // magnetometer at its center
        queue_sample(-1, -1, -1, -1, -1, -1);
        queue_sample(1, 0, 0, 1, 0, 0);
        queue_sample(0, -1, 1, 0, 1, -1);
        queue_sample(500, -700, 1500, -2000, 3000, -1000);
        drain();

        // Unimplemented register indexes must leave the calibration alone.
        steady = 1'b0;
        write_cal(REG_SPARE_6, 13'h1fff);
        write_cal(REG_SPARE_7, 13'h0000);
        queue_random(150);
        drain();

        // Zero gains: every axis drops out and the heading collapses.
        set_calibration(13'h0000, 13'h0000, 13'h0000, 12'd0, 12'd0, 12'd0);
        queue_random(60);
        drain();

        // Most negative centers, largest gains.
        set_calibration(13'h1000, 13'h1000, 13'h1000, 12'hfff, 12'hfff, 12'hfff);
        queue_random(150);
        drain();

        // Most positive centers with one zero gain. The receiver holds off
        // for a long stretch during this phase.
        set_calibration(13'h0fff, 13'h0fff, 13'h0fff, 12'hfff, 12'd0, 12'd1);
        queue_random(200);
        drain();

        // Random calibration with random bits.
        set_calibration(13'($urandom), 13'($urandom), 13'($urandom),
                        12'($urandom), 12'($urandom), 12'($urandom));
        queue_random(150);
        drain();

        // Back to a realistic calibration, no idling on either side.
        steady = 1'b1;
        set_calibration(13'sd23, -13'sd147, 13'sd1, 12'd783, 12'd787, 12'd821);
        queue_random(150);
        drain();

        if (failures == 0) begin
            $display("tilt_compensated_compass_top regression: pass");
        end else begin
            $display("tilt_compensated_compass_top regression: fail");
        end
        $finish;
    end

    // ---------------------------------------------------------------------
    // Driver: offers queued samples, predicting each one as it is offered.
    // The next valid value is settled first so it is assigned once per edge.
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin
        sensor_sample_t smp;
        logic next_valid;
        next_valid = s_tvalid;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                samples_taken++;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                end else if (pending_samples.size() != 0) begin
                    smp = pending_samples.pop_front();
                    expected_angles.push_back(predict_attitude(smp));
                    s_tdata <= {5'b0, smp.mz, smp.my, smp.mx, smp.az, smp.ay, smp.ax};
                    next_valid = 1'b1;
                    send_gap <= steady ? 0 : $urandom_range(0, 3);
                end
            end
        end
        s_tvalid <= next_valid;
    end

    // Long receiver hold-off, so the pipeline fills and stalls its input.
    always @(posedge aclk) begin
        if (!hold_done && samples_taken >= 400) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: checks each result transfer against the oldest prediction.
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin
        attitude_t want;
        logic next_ready;
        int   gap;
        next_ready = m_tready;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_angles.size() == 0) begin
                    $error("result transfer with no sample outstanding: %h", m_tdata);
                    failures++;
                end else begin
                    want = expected_angles.pop_front();
                    if (m_tdata[15:0] !== want.pitch) begin
                        $error("pitch_angle: expected %0d, got %0d",
                               $signed(want.pitch), $signed(m_tdata[15:0]));
                        failures++;
                    end
                    if (m_tdata[31:16] !== want.roll) begin
                        $error("roll_angle: expected %0d, got %0d",
                               $signed(want.roll), $signed(m_tdata[31:16]));
                        failures++;
                    end
                    if (m_tdata[47:32] !== want.heading) begin
                        $error("heading_angle: expected %0d, got %0d",
                               $signed(want.heading), $signed(m_tdata[47:32]));
                        failures++;
                    end
                end
                gap = steady ? 0 : $urandom_range(0, 3);
                recv_gap <= gap;
                next_ready = (gap == 0);
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                next_ready = 1'b0;
            end else begin
                next_ready = 1'b1;
            end
            if (hold_left > 1) next_ready = 1'b0;
        end
        m_tready <= next_ready;
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tilt_compensated_compass_top regression: fail");
            $finish;
        end
    end

endmodule

`default_nettype wire
